>>> design/ssi_pkg.sv
// ssi_pkg: shared types and constants for the sorted slot inventory.
// No dependencies.
`default_nettype none
package ssi_pkg;
    localparam int SLOTS_DEF      = 32;
    localparam int CATEGORIES_DEF = 8;
    localparam int ID_W           = 8;
    localparam int CAT_W          = 3;

    typedef enum logic [1:0] {
        OP_QUERY  = 2'd0,
        OP_ADD    = 2'd1,
        OP_REMOVE = 2'd2,
        OP_CLEAR  = 2'd3
    } op_t;

    typedef struct packed {
        logic [1:0]       operation;
        logic [ID_W-1:0]  item_id;
        logic [CAT_W-1:0] item_category;
    } in_item_t;

    typedef struct packed {
        logic       done_ok;
        logic       is_present;
        logic       has_room;
        logic [4:0] first_free_index;
        logic       free_found;
        logic [5:0] category_count;
        logic [8:0] total_count;
    } out_item_t;
endpackage
`default_nettype wire

>>> design/ssi_ram.sv
// ssi_ram: generic RAM with one write port and one read port, with registered read.
// No dependencies.
`default_nettype none
module ssi_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

>>> design/sorted_slot_inventory_core.sv
// sorted_slot_inventory_core: top level, sequencer over one slot RAM.
// Depends on ssi_pkg and ssi_ram.
//
//  channel | signals                    | payload
//  input   | in_valid, in_ready         | in_data  (ssi_pkg::in_item_t)
//  output  | out_valid, out_ready       | out_data (ssi_pkg::out_item_t)
//
// A query scans the category's slots, one slot read a cycle, before its result; an add
// then writes the first free slot if there is one. A remove adds a search for the item and,
// when found, an exchange sort through S_RM_RDI to S_RM_NEXT for each of SLOTS*(SLOTS-1)/2 slot pairs.
// Reset starts a clearing pass over all SLOTS*CATEGORIES entries; clear op repeats it.
// in_ready is high only when idle and the output register is empty.
`default_nettype none
module sorted_slot_inventory_core #(
    parameter int SLOTS      = ssi_pkg::SLOTS_DEF,
    parameter int CATEGORIES = ssi_pkg::CATEGORIES_DEF
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire ssi_pkg::in_item_t  in_data,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output ssi_pkg::out_item_t      out_data
);
    import ssi_pkg::*;

    localparam int SW    = $clog2(SLOTS);
    localparam int CW    = (CATEGORIES > 1) ? $clog2(CATEGORIES) : 1;
    localparam int DEPTH = SLOTS * CATEGORIES;
    localparam int AW    = $clog2(DEPTH);

    typedef enum logic [3:0] {
        S_CLR, S_IDLE, S_SCAN, S_ADD, S_RM_FIND, S_RM_RDI, S_RM_RDJ, S_RM_CMP,
        S_RM_WRJ, S_RM_NEXT, S_DONE
    } state_t;

    state_t            state_reg;
    logic [AW:0]       clr_reg;
    logic [SW:0]       idx_reg;
    logic [SW:0]       j_reg;
    logic [SW-1:0]     i_reg;
    logic [ID_W-1:0]   ti_reg;
    logic [ID_W-1:0]   tj_reg;
    in_item_t          req_reg;
    logic              valid_cat_reg;
    logic              present_reg;
    logic              free_reg;
    logic [SW-1:0]     ffi_reg;
    logic              ok_reg;
    logic [6:0]        cnt_reg [CATEGORIES];
    logic [9:0]        total_reg;
    logic              out_valid_reg;
    out_item_t         out_reg;

    logic              we;
    logic [AW-1:0]     waddr;
    logic [ID_W-1:0]   wdata;
    logic [AW-1:0]     raddr;
    logic [ID_W-1:0]   rdata;
    logic [CW-1:0]     cat;
    logic              in_cat_ok;

    assign cat       = CW'(req_reg.item_category);
    assign in_cat_ok = 32'(in_data.item_category) < CATEGORIES;

    function automatic logic [AW-1:0] addr_of(input logic [CW-1:0] c, input logic [SW-1:0] s);
        return AW'(c) * AW'(SLOTS) + AW'(s);
    endfunction

    ssi_ram #(.WIDTH(ID_W), .DEPTH(DEPTH)) u_ram (
        .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
    );

    always_comb
    begin
        we    = 1'b0;
        waddr = addr_of(cat, i_reg);
        wdata = '0;
        raddr = addr_of(cat, idx_reg[SW-1:0]);
        unique case (state_reg)
            S_CLR:
            begin
                we    = 1'b1;
                waddr = clr_reg[AW-1:0];
            end
            S_ADD:
            begin
                we    = free_reg && req_reg.item_id != '0;
                waddr = addr_of(cat, ffi_reg);
                wdata = req_reg.item_id;
            end
            S_RM_FIND:
            begin
                we    = idx_reg != '0 && rdata == req_reg.item_id;
                waddr = addr_of(cat, SW'(idx_reg - 1'b1));
            end
            S_RM_RDI: raddr = addr_of(cat, i_reg);
            S_RM_RDJ: raddr = addr_of(cat, j_reg[SW-1:0]);
            S_RM_CMP:
            begin
                we    = rdata != '0 && (ti_reg == '0 || ti_reg > rdata);
                waddr = addr_of(cat, i_reg);
                wdata = rdata;
            end
            S_RM_WRJ:
            begin
                we    = tj_reg != '0 && (ti_reg == '0 || ti_reg > tj_reg);
                waddr = addr_of(cat, j_reg[SW-1:0]);
                wdata = ti_reg;
            end
            default: ;
        endcase
    end

    assign in_ready  = state_reg == S_IDLE && !out_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLR;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
            total_reg     <= '0;
            req_reg       <= '0;
            ok_reg        <= 1'b0;
            for (int k = 0; k < CATEGORIES; k++)
            begin
                cnt_reg[k] <= '0;
            end
        end
        else
        begin
            if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_CLR:
                begin
                    clr_reg <= clr_reg + 1'b1;
                    if (clr_reg == (AW+1)'(DEPTH - 1))
                    begin
                        state_reg <= (req_reg.operation == OP_CLEAR && out_valid_reg == 1'b0
                                      && ok_reg) ? S_DONE : S_IDLE;
                    end
                end
                S_IDLE:
                begin
                    if (in_valid && in_ready)
                    begin
                        req_reg       <= in_data;
                        valid_cat_reg <= in_cat_ok;
                        present_reg   <= 1'b0;
                        free_reg      <= 1'b0;
                        ffi_reg       <= '0;
                        idx_reg       <= '0;
                        clr_reg       <= '0;
                        ok_reg        <= !in_cat_ok && in_data.operation == OP_CLEAR;
                        if (in_cat_ok)
                        begin
                            state_reg <= S_SCAN;
                        end
                        else if (in_data.operation == OP_CLEAR)
                        begin
                            state_reg <= S_CLR;
                        end
                        else
                        begin
                            state_reg <= S_DONE;
                        end
                    end
                    else
                    begin
                        ok_reg <= 1'b0;
                    end
                end
                S_SCAN:
                begin
                    if (idx_reg != '0)
                    begin
                        if (rdata == req_reg.item_id)
                        begin
                            present_reg <= 1'b1;
                        end
                        if (!free_reg && rdata == '0)
                        begin
                            free_reg <= 1'b1;
                            ffi_reg  <= SW'(idx_reg - 1'b1);
                        end
                    end
                    if (idx_reg == (SW+1)'(SLOTS))
                    begin
                        idx_reg <= '0;
                        unique case (req_reg.operation)
                            OP_ADD:    state_reg <= S_ADD;
                            OP_REMOVE: state_reg <= S_RM_FIND;
                            OP_CLEAR:
                            begin
                                ok_reg    <= 1'b1;
                                clr_reg   <= '0;
                                state_reg <= S_CLR;
                            end
                            default:   state_reg <= S_DONE;
                        endcase
                    end
                    else
                    begin
                        idx_reg <= idx_reg + 1'b1;
                    end
                end
                S_ADD:
                begin
                    if (free_reg && req_reg.item_id != '0)
                    begin
                        ok_reg       <= 1'b1;
                        cnt_reg[cat] <= cnt_reg[cat] + 1'b1;
                        total_reg    <= total_reg + 1'b1;
                    end
                    state_reg <= S_DONE;
                end
                S_RM_FIND:
                begin
                    idx_reg <= idx_reg + 1'b1;
                    if (req_reg.item_id == '0 || !present_reg)
                    begin
                        state_reg <= S_DONE;
                    end
                    else if (idx_reg != '0 && rdata == req_reg.item_id)
                    begin
                        ok_reg       <= 1'b1;
                        cnt_reg[cat] <= cnt_reg[cat] - 1'b1;
                        total_reg    <= total_reg - 1'b1;
                        i_reg        <= '0;
                        j_reg        <= (SW+1)'(1);
                        state_reg    <= S_RM_RDI;
                    end
                end
                S_RM_RDI: state_reg <= S_RM_RDJ;
                S_RM_RDJ:
                begin
                    ti_reg    <= rdata;
                    state_reg <= S_RM_CMP;
                end
                S_RM_CMP:
                begin
                    tj_reg    <= rdata;
                    state_reg <= S_RM_WRJ;
                end
                S_RM_WRJ:
                begin
                    state_reg <= S_RM_NEXT;
                end
                S_RM_NEXT:
                begin
                    if (j_reg == (SW+1)'(SLOTS - 1))
                    begin
                        if (i_reg == SW'(SLOTS - 2))
                        begin
                            state_reg <= S_DONE;
                        end
                        else
                        begin
                            i_reg     <= i_reg + 1'b1;
                            j_reg     <= (SW+1)'(i_reg) + (SW+1)'(2);
                            state_reg <= S_RM_RDI;
                        end
                    end
                    else
                    begin
                        j_reg     <= j_reg + 1'b1;
                        state_reg <= S_RM_RDI;
                    end
                end
                S_DONE:
                begin
                    out_valid_reg            <= 1'b1;
                    out_reg.done_ok          <= ok_reg && req_reg.operation != OP_CLEAR;
                    out_reg.is_present       <= present_reg;
                    out_reg.has_room         <= free_reg && req_reg.item_id != '0;
                    out_reg.first_free_index <= 5'(ffi_reg);
                    out_reg.free_found       <= free_reg;
                    out_reg.category_count   <= (valid_cat_reg && req_reg.operation != OP_CLEAR)
                                                ? 6'(cnt_reg[cat]) : '0;
                    out_reg.total_count      <= (req_reg.operation == OP_CLEAR)
                                                ? '0 : 9'(total_reg);
                    state_reg                <= S_IDLE;
                    if (req_reg.operation == OP_CLEAR)
                    begin
                        total_reg <= '0;
                        for (int k = 0; k < CATEGORIES; k++)
                        begin
                            cnt_reg[k] <= '0;
                        end
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

`ifndef SYNTHESIS
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> !in_ready) else $error("accept while busy");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> out_valid) else $error("result dropped");
    a_total_range: assert property (@(posedge clk) disable iff (!rst_n)
        32'(total_reg) <= DEPTH) else $error("total out of range");
`endif
endmodule
`default_nettype wire

>>> bench/tb_sorted_slot_inventory_core.sv
// Testbench for sorted_slot_inventory_core: directed and random add, remove, query and
// clear items, checked against a scoreboard that models the slot store. Depends on ssi_pkg.
`timescale 1ns / 1ps

module tb_sorted_slot_inventory_core;
    import ssi_pkg::*;

    localparam int NSLOT = SLOTS_DEF;
    localparam int NCAT  = CATEGORIES_DEF;
    localparam int RANDOM_ITEMS = 1110;

    class inventory_scoreboard;
        logic [7:0] slots [NCAT][NSLOT];
        int unsigned cat_occupied [NCAT];
        int unsigned all_occupied;
        out_item_t expected_results [$];
        int errors;

        function new();
            foreach (slots[c, s]) slots[c][s] = '0;
            foreach (cat_occupied[c]) cat_occupied[c] = 0;
            all_occupied = 0;
            errors = 0;
        endfunction

        function void resort(int c);
            logic [7:0] t;
            for (int i = 0; i < NSLOT; i++)
                for (int j = i + 1; j < NSLOT; j++)
                    if (slots[c][j] != 0 && (slots[c][i] == 0 || slots[c][i] > slots[c][j]))
                    begin
                        t = slots[c][i];
                        slots[c][i] = slots[c][j];
                        slots[c][j] = t;
                    end
        endfunction

        function void note_item(in_item_t it);
            out_item_t r;
            int c;
            logic found, present, room, ok;
            int free_idx;
            c = it.item_category;
            found = 0;
            present = 0;
            ok = 0;
            free_idx = 0;
            if (c < NCAT) begin
                for (int i = 0; i < NSLOT; i++) begin
                    if (slots[c][i] == it.item_id) present = 1;
                    if (!found && slots[c][i] == 0) begin
                        found = 1;
                        free_idx = i;
                    end
                end
            end
            room = (it.item_id != 0) && found;
            if (it.operation == OP_ADD) begin
                if (room) begin
                    slots[c][free_idx] = it.item_id;
                    cat_occupied[c]++;
                    all_occupied++;
                    ok = 1;
                end
            end else if (it.operation == OP_REMOVE) begin
                if (c < NCAT && it.item_id != 0) begin
                    for (int i = 0; i < NSLOT; i++) begin
                        if (!ok && slots[c][i] == it.item_id) begin
                            slots[c][i] = 0;
                            cat_occupied[c]--;
                            all_occupied--;
                            resort(c);
                            ok = 1;
                        end
                    end
                end
            end else if (it.operation == OP_CLEAR) begin
                foreach (slots[k, s]) slots[k][s] = '0;
                foreach (cat_occupied[k]) cat_occupied[k] = 0;
                all_occupied = 0;
            end
            r.done_ok = ok;
            r.is_present = present;
            r.has_room = room;
            r.first_free_index = free_idx[4:0];
            r.free_found = found;
            r.category_count = (c < NCAT) ? cat_occupied[c][5:0] : '0;
            r.total_count = all_occupied[8:0];
            expected_results.push_back(r);
        endfunction

        function void check_result(out_item_t got);
            out_item_t e;
            if (expected_results.size() == 0) begin
                $error("unexpected result %p", got);
                errors++;
                return;
            end
            e = expected_results.pop_front();
            if (got.done_ok !== e.done_ok) begin
                $error("done_ok: expected %0d, got %0d", e.done_ok, got.done_ok);
                errors++;
            end
            if (got.is_present !== e.is_present) begin
                $error("is_present: expected %0d, got %0d", e.is_present, got.is_present);
                errors++;
            end
            if (got.has_room !== e.has_room) begin
                $error("has_room: expected %0d, got %0d", e.has_room, got.has_room);
                errors++;
            end
            if (got.first_free_index !== e.first_free_index) begin
                $error("first_free_index: expected %0d, got %0d",
                       e.first_free_index, got.first_free_index);
                errors++;
            end
            if (got.free_found !== e.free_found) begin
                $error("free_found: expected %0d, got %0d", e.free_found, got.free_found);
                errors++;
            end
            if (got.category_count !== e.category_count) begin
                $error("category_count: expected %0d, got %0d",
                       e.category_count, got.category_count);
                errors++;
            end
            if (got.total_count !== e.total_count) begin
                $error("total_count: expected %0d, got %0d", e.total_count, got.total_count);
                errors++;
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_ready;
    in_item_t in_data;
    logic out_valid;
    logic out_ready;
    out_item_t out_data;

    inventory_scoreboard sb;
    int sender_idle_pct;
    int receiver_stall_pct;

    sorted_slot_inventory_core DUT (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .in_data(in_data),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .out_data(out_data)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    function automatic in_item_t make_item(op_t op, int id, int cat);
        in_item_t it;
        it.operation = op;
        it.item_id = id[7:0];
        it.item_category = cat[2:0];
        return it;
    endfunction

    function automatic in_item_t random_item();
        int r;
        int id;
        int cat;
        op_t op;
        r = $urandom_range(99);
        if (r < 45) op = OP_ADD;
        else if (r < 75) op = OP_REMOVE;
        else if (r < 99) op = OP_QUERY;
        else op = OP_CLEAR;
        r = $urandom_range(99);
        if (r < 70) id = $urandom_range(12, 1);
        else if (r < 80) id = 0;
        else id = $urandom_range(255);
        cat = ($urandom_range(1)) ? $urandom_range(1) : $urandom_range(NCAT - 1);
        return make_item(op, id, cat);
    endfunction

    // called at a falling edge; returns at the falling edge after acceptance
    task automatic send_item(in_item_t it);
        if ($urandom_range(99) < sender_idle_pct) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(4, 1)) @(negedge clk);
        end
        in_data <= it;
        in_valid <= 1'b1;
        do @(posedge clk); while (!in_ready);
        sb.note_item(it);
        @(negedge clk);
    endtask

    task automatic set_phase(int n);
        case (n % 4)
            0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
            1: begin sender_idle_pct = 57; receiver_stall_pct = 0;  end
            2: begin sender_idle_pct = 0;  receiver_stall_pct = 57; end
            default: begin sender_idle_pct = 33; receiver_stall_pct = 33; end
        endcase
    endtask

    initial
    begin
        forever begin
            @(posedge clk);
            if (rst_n && out_valid && out_ready) sb.check_result(out_data);
            @(negedge clk);
            out_ready <= ($urandom_range(99) >= receiver_stall_pct);
        end
    end

    initial
    begin
        in_item_t directed [$];
        int waited;
        sb = new();
        sender_idle_pct = 0;
        receiver_stall_pct = 0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        out_ready = 1'b0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        directed.push_back(make_item(OP_QUERY, 0, 0));
        directed.push_back(make_item(OP_ADD, 0, 0));
        directed.push_back(make_item(OP_REMOVE, 0, 0));
        directed.push_back(make_item(OP_ADD, 255, 7));
        directed.push_back(make_item(OP_ADD, 1, 7));
        directed.push_back(make_item(OP_ADD, 255, 7));
        directed.push_back(make_item(OP_ADD, 128, 7));
        directed.push_back(make_item(OP_REMOVE, 255, 7));
        directed.push_back(make_item(OP_QUERY, 255, 7));
        directed.push_back(make_item(OP_REMOVE, 77, 7));
        directed.push_back(make_item(OP_QUERY, 0, 7));
        directed.push_back(make_item(OP_ADD, 170, 5));
        directed.push_back(make_item(OP_ADD, 85, 2));
        directed.push_back(make_item(OP_REMOVE, 85, 2));
        directed.push_back(make_item(OP_CLEAR, 255, 7));
        directed.push_back(make_item(OP_QUERY, 255, 7));
        directed.push_back(make_item(OP_CLEAR, 0, 0));
        foreach (directed[k]) send_item(directed[k]);

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            set_phase(n / 70);
            send_item(random_item());
        end
        in_valid <= 1'b0;

        waited = 0;
        while (sb.expected_results.size() != 0 && waited < 200000) begin
            @(posedge clk);
            waited++;
        end
        repeat (1200) @(posedge clk);
        if (sb.errors == 0 && sb.expected_results.size() == 0)
            $display("tb_sorted_slot_inventory_core: done, clean");
        else
            $display("tb_sorted_slot_inventory_core: done, errors");
        $finish;
    end

    initial
    begin
        #150ms;
        $display("tb_sorted_slot_inventory_core: done, errors");
        $finish;
    end
endmodule
